### hw/rtl/utf8_cursor_locate_macros.svh
// Assertion macros shared by the checker modules of the cursor locator.
`ifndef UTF8_CURSOR_LOCATE_MACROS_SVH
`define UTF8_CURSOR_LOCATE_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define UCL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Same, on the usual clock and reset names of this project.
`define UCL_ASSERT_CLK(name, prop) `UCL_ASSERT(name, clk_i, rst_ni, prop)

`endif

### hw/rtl/ucl_pkg.sv
// Shared constants and beat types of the UTF-8 cursor locator.
package ucl_pkg;

  localparam int unsigned OFFSET_BITS = 16;
  localparam int unsigned OUT_OFS_W   = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LINE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COLUMN = 1'd1;

  localparam logic [7:0] CHAR_NUL      = 8'h00;
  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] ASCII_LIMIT   = 8'd128;
  localparam logic [7:0] LEAD_MIN      = 8'd194;
  localparam logic [7:0] LEAD_MAX      = 8'd244;
  localparam logic [7:0] LEAD_3B_MIN   = 8'd224;
  localparam logic [7:0] LEAD_4B_MIN   = 8'd240;
  localparam logic [7:0] LEAD_E0       = 8'd224;
  localparam logic [7:0] LEAD_ED       = 8'd237;
  localparam logic [7:0] LEAD_F0       = 8'd240;
  localparam logic [7:0] LEAD_F4       = 8'd244;
  localparam logic [7:0] CONT_MASK     = 8'hC0;
  localparam logic [7:0] CONT_TAG      = 8'h80;
  localparam logic [7:0] E0_SECOND_MIN = 8'd160;
  localparam logic [7:0] ED_SECOND_LIM = 8'd160;
  localparam logic [7:0] F0_SECOND_MIN = 8'd144;
  localparam logic [7:0] F4_SECOND_LIM = 8'd144;

  typedef struct packed {
    logic                 found;
    logic [OUT_OFS_W-1:0] cursor_offset;
    logic [OUT_OFS_W-1:0] line_start_offset;
  } out_beat_t;

endpackage

### hw/rtl/ucl_if.sv
// Valid/ready channel interfaces for text bytes in and verdicts out.
interface ucl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       first_byte;

  modport source (output valid, output text_byte, output first_byte, input ready);
  modport sink   (input valid, input text_byte, input first_byte, output ready);
endinterface

interface ucl_out_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [ucl_pkg::OUT_OFS_W-1:0]  cursor_offset;
  logic [ucl_pkg::OUT_OFS_W-1:0]  line_start_offset;

  modport source (output valid, output found, output cursor_offset,
                  output line_start_offset, input ready);
  modport sink   (input valid, input found, input cursor_offset,
                  input line_start_offset, output ready);
endinterface

### hw/rtl/utf8_cursor_locate.sv
// Top level of the UTF-8 cursor locator: byte stream in, one verdict per text out.
//
// The text streams in on in_i, one byte per beat; first_byte marks the first
// byte of a new text and restarts the search, a zero byte ends the text.
// Before streaming, target_line and target_column are written through the
// cfg_we_i / cfg_idx_i / cfg_data_i port (index 0 line, index 1 column).
// Each text gives at most one beat on out_o: found with the cursor offset and
// the line start offset, or a failure. Bytes that do not decide the verdict
// give no output beat, and bytes after a verdict are dropped until the next
// first byte.
// One byte is accepted every cycle while in_i.ready is high. A byte is held in
// an input register, its state update and verdict are formed combinationally
// from compares and a decrement, and the verdict is registered in the output register.
// A one-entry skid buffer behind the output register lets bytes keep flowing
// while a verdict waits; in_i.ready drops only when both the skid buffer and
// the input register are occupied.
// Reset clears the search to its idle state, the configuration to zero and
// empties all stages.
module utf8_cursor_locate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ucl_in_if.sink                          in_i,
  ucl_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [ucl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ucl_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned OB = ucl_pkg::OFFSET_BITS;

  typedef enum logic [1:0] {
    PH_DONE,
    PH_SKIP,
    PH_LINE
  } phase_e;

  typedef enum logic [2:0] {
    LC_PLAIN,
    LC_E0,
    LC_ED,
    LC_F0,
    LC_F4
  } lead_e;

  // Configuration.
  logic [15:0] target_line_q, target_column_q;

  // Input register.
  logic       pipe_valid_q;
  logic [7:0] pipe_byte_q;
  logic       pipe_first_q;

  // Search state.
  phase_e      phase_q, phase_d;
  logic [15:0] lines_q, lines_d;
  logic [15:0] cols_q, cols_d;
  logic [1:0]  cont_q, cont_d;
  lead_e       lead_q, lead_d;
  logic [OB:0] pos_q, pos_d;
  logic [OB-1:0] lbegin_q, lbegin_d;

  // Output register and skid buffer.
  logic                out_valid_q, skid_valid_q;
  ucl_pkg::out_beat_t  out_q, skid_q;

  logic                in_accept, process, res_valid, out_free;
  ucl_pkg::out_beat_t  res_beat;

  assign in_i.ready = !pipe_valid_q || !skid_valid_q;
  assign in_accept  = in_i.valid && in_i.ready;
  assign process    = pipe_valid_q && !skid_valid_q;
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    logic          go, fail, hit, done_char;
    logic [OB-1:0] hit_ofs;
    logic [OB:0]   next;
    logic [1:0]    more;
    logic [1:0]    units;
    logic [7:0]    b;

    go        = 1'b0;
    fail      = 1'b0;
    hit       = 1'b0;
    done_char = 1'b0;
    hit_ofs   = '0;
    next      = '0;
    more      = '0;
    units     = '0;
    b         = pipe_byte_q;

    phase_d  = phase_q;
    lines_d  = lines_q;
    cols_d   = cols_q;
    cont_d   = cont_q;
    lead_d   = lead_q;
    pos_d    = pos_q;
    lbegin_d = lbegin_q;

    if (process) begin
      go = 1'b1;
      if (pipe_first_q) begin
        lines_d  = '0;
        cols_d   = '0;
        cont_d   = '0;
        lead_d   = LC_PLAIN;
        pos_d    = '0;
        lbegin_d = '0;
        phase_d  = PH_SKIP;
        if (target_line_q == '0) begin
          cols_d  = target_column_q;
          phase_d = PH_LINE;
          if (target_column_q == '0) begin
            // The cursor sits at the very start of the text.
            hit     = 1'b1;
            hit_ofs = '0;
            go      = 1'b0;
          end
        end
      end else if (phase_q == PH_DONE) begin
        go = 1'b0;
      end

      if (go) begin
        if (pos_d[OB]) begin
          fail = 1'b1;
        end else begin
          next  = pos_d + (OB+1)'(1);
          pos_d = next;
          if (phase_d == PH_SKIP) begin
            if (b == ucl_pkg::CHAR_NUL) begin
              fail = 1'b1;
            end else if (b == ucl_pkg::CHAR_LF) begin
              lines_d = lines_d + 16'd1;
              if (lines_d == target_line_q) begin
                if (next[OB]) begin
                  fail = 1'b1;
                end else begin
                  lbegin_d = next[OB-1:0];
                  cols_d   = target_column_q;
                  cont_d   = '0;
                  lead_d   = LC_PLAIN;
                  phase_d  = PH_LINE;
                  if (target_column_q == '0) begin
                    hit     = 1'b1;
                    hit_ofs = next[OB-1:0];
                  end
                end
              end
            end
          end else if (cont_d == '0) begin
            if (b == ucl_pkg::CHAR_NUL || b == ucl_pkg::CHAR_CR || b == ucl_pkg::CHAR_LF) begin
              fail = 1'b1;
            end else if ((b >= ucl_pkg::ASCII_LIMIT && b < ucl_pkg::LEAD_MIN) ||
                         b > ucl_pkg::LEAD_MAX) begin
              fail = 1'b1;
            end else if (b < ucl_pkg::ASCII_LIMIT) begin
              cols_d    = cols_d - 16'd1;
              done_char = 1'b1;
            end else begin
              more  = (b < ucl_pkg::LEAD_3B_MIN) ? 2'd1 :
                      (b < ucl_pkg::LEAD_4B_MIN) ? 2'd2 : 2'd3;
              units = (more == 2'd3) ? 2'd2 : 2'd1;
              if (cols_d < 16'(units)) begin
                // A four-byte character would straddle the cursor.
                fail = 1'b1;
              end else begin
                cols_d = cols_d - 16'(units);
                cont_d = more;
                lead_d = (b == ucl_pkg::LEAD_E0) ? LC_E0 :
                         (b == ucl_pkg::LEAD_ED) ? LC_ED :
                         (b == ucl_pkg::LEAD_F0) ? LC_F0 :
                         (b == ucl_pkg::LEAD_F4) ? LC_F4 : LC_PLAIN;
              end
            end
          end else begin
            if ((b & ucl_pkg::CONT_MASK) != ucl_pkg::CONT_TAG ||
                (lead_d == LC_E0 && b < ucl_pkg::E0_SECOND_MIN) ||
                (lead_d == LC_ED && b >= ucl_pkg::ED_SECOND_LIM) ||
                (lead_d == LC_F0 && b < ucl_pkg::F0_SECOND_MIN) ||
                (lead_d == LC_F4 && b >= ucl_pkg::F4_SECOND_LIM)) begin
              fail = 1'b1;
            end else begin
              lead_d = LC_PLAIN;
              cont_d = cont_d - 2'd1;
              if (cont_d == '0) begin
                done_char = 1'b1;
              end
            end
          end

          if (done_char && cols_d == '0) begin
            if (next[OB]) begin
              fail = 1'b1;
            end else begin
              hit     = 1'b1;
              hit_ofs = next[OB-1:0];
            end
          end
        end
      end
    end

    res_valid                  = fail || hit;
    res_beat.found             = hit && !fail;
    res_beat.cursor_offset     = (hit && !fail) ? ucl_pkg::OUT_OFS_W'(hit_ofs) : '0;
    res_beat.line_start_offset = ucl_pkg::OUT_OFS_W'(lbegin_d);
    if (res_valid) begin
      phase_d = PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_line_q   <= '0;
      target_column_q <= '0;
      pipe_valid_q    <= 1'b0;
      phase_q         <= PH_DONE;
      lines_q         <= '0;
      cols_q          <= '0;
      cont_q          <= '0;
      lead_q          <= LC_PLAIN;
      pos_q           <= '0;
      lbegin_q        <= '0;
      out_valid_q     <= 1'b0;
      skid_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ucl_pkg::CFG_TARGET_LINE:   target_line_q   <= cfg_data_i;
          ucl_pkg::CFG_TARGET_COLUMN: target_column_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (in_accept) begin
        pipe_valid_q <= 1'b1;
      end else if (process) begin
        pipe_valid_q <= 1'b0;
      end

      phase_q  <= phase_d;
      lines_q  <= lines_d;
      cols_q   <= cols_d;
      cont_q   <= cont_d;
      lead_q   <= lead_d;
      pos_q    <= pos_d;
      lbegin_q <= lbegin_d;

      // The skid buffer drains first; a new verdict only arrives while it is empty.
      if (out_free) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= res_valid;
        end
      end else if (res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pipe_byte_q  <= in_i.text_byte;
      pipe_first_q <= in_i.first_byte;
    end
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_beat;
    end else if (res_valid) begin
      skid_q <= res_beat;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.found             = out_q.found;
  assign out_o.cursor_offset     = out_q.cursor_offset;
  assign out_o.line_start_offset = out_q.line_start_offset;

endmodule

### hw/rtl/ucl_checker.sv
// Port-level checks of the cursor locator, bound to the top level.
`include "utf8_cursor_locate_macros.svh"

module ucl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic                           found_i,
  input logic [ucl_pkg::OUT_OFS_W-1:0]  cursor_offset_i,
  input logic [ucl_pkg::OUT_OFS_W-1:0]  line_start_offset_i
);

  logic [2*ucl_pkg::OUT_OFS_W:0] out_payload;

  assign out_payload = {found_i, cursor_offset_i, line_start_offset_i};

  // A stalled verdict beat keeps its payload.
  `UCL_ASSERT_CLK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload))

  // A failure carries no cursor offset.
  `UCL_ASSERT_CLK(a_fail_zero_cursor, out_valid_i && !found_i |-> cursor_offset_i == '0)

  // The cursor never lies before the start of its line.
  `UCL_ASSERT_CLK(a_cursor_after_line, out_valid_i && found_i |-> cursor_offset_i >= line_start_offset_i)

  // Input backpressure only comes from a verdict waiting at the output.
  `UCL_ASSERT_CLK(a_stall_needs_output, !in_ready_i |-> out_valid_i)

endmodule

bind utf8_cursor_locate ucl_checker u_ucl_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .found_i             (out_o.found),
  .cursor_offset_i     (out_o.cursor_offset),
  .line_start_offset_i (out_o.line_start_offset)
);

### tb/sv/tb_utf8_cursor_locate.sv
// Self-checking testbench for the UTF-8 cursor locator: directed texts, a hold-off, random texts.
module tb_utf8_cursor_locate;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned PRESSURE_TEXTS = 40;
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned PHASE_BYTES   = 150;
  localparam longint unsigned CYCLE_LIMIT = 1500000;
  localparam longint unsigned OFS_MAX = (64'd1 << ucl_pkg::OFFSET_BITS) - 1;

  typedef enum logic [1:0] {SRCH_IDLE, SRCH_SKIP, SRCH_LINE} search_e;
  typedef enum logic [2:0] {LK_PLAIN, LK_E0, LK_ED, LK_F0, LK_F4} lead_e;

  // One directed text: the bytes are written in stream order, right-aligned.
  typedef struct packed {
    logic               fresh;
    logic [15:0]        line;
    logic [15:0]        col;
    logic [3:0]         len;
    logic [63:0]        text;
    logic               typed;
    ucl_pkg::out_beat_t exp;
  } dir_row_t;

  localparam ucl_pkg::out_beat_t REJECTED = '0;

  dir_row_t dir_rows [24] = '{
    '{1'b1, 16'd0, 16'd0, 4'd1, 64'h41, 1'b1, '{1'b1, 16'd0, 16'd0}},
    '{1'b0, 16'd0, 16'd0, 4'd2, 64'h4243, 1'b0, '0},
    '{1'b1, 16'd0, 16'd1, 4'd1, 64'h7F, 1'b1, '{1'b1, 16'd1, 16'd0}},
    '{1'b1, 16'd0, 16'd1, 4'd1, 64'h80, 1'b1, REJECTED},
    '{1'b1, 16'd0, 16'd1, 4'd1, 64'hC1, 1'b1, REJECTED},
    '{1'b1, 16'd0, 16'd1, 4'd1, 64'hF5, 1'b1, REJECTED},
    '{1'b1, 16'd0, 16'd1, 4'd2, 64'hC280, 1'b1, '{1'b1, 16'd2, 16'd0}},
    '{1'b1, 16'd0, 16'd1, 4'd3, 64'hE09F80, 1'b1, REJECTED},
    '{1'b1, 16'd0, 16'd1, 4'd2, 64'hEDA0, 1'b1, REJECTED},
    '{1'b1, 16'd0, 16'd1, 4'd1, 64'hF0, 1'b1, REJECTED},
    '{1'b1, 16'd0, 16'd2, 4'd2, 64'hF08F, 1'b1, REJECTED},
    '{1'b1, 16'd0, 16'd2, 4'd4, 64'hF0908080, 1'b1, '{1'b1, 16'd4, 16'd0}},
    '{1'b1, 16'd0, 16'd2, 4'd2, 64'hF490, 1'b1, REJECTED},
    '{1'b1, 16'd0, 16'd2, 4'd2, 64'hC341, 1'b1, REJECTED},
    '{1'b1, 16'd0, 16'd2, 4'd2, 64'h410D, 1'b1, REJECTED},
    '{1'b1, 16'd0, 16'd2, 4'd2, 64'h410A, 1'b1, REJECTED},
    '{1'b1, 16'd0, 16'd2, 4'd2, 64'h4100, 1'b1, REJECTED},
    '{1'b1, 16'd0, 16'd3, 4'd2, 64'h4142, 1'b0, '0},
    '{1'b1, 16'd1, 16'd0, 4'd4, 64'h41420A58, 1'b1, '{1'b1, 16'd3, 16'd3}},
    '{1'b1, 16'd1, 16'd1, 4'd3, 64'h0AC3A9, 1'b0, '0},
    '{1'b1, 16'd1, 16'd2, 4'd3, 64'h0A410D, 1'b1, '{1'b0, 16'd0, 16'd1}},
    '{1'b1, 16'd2, 16'd0, 4'd3, 64'h410A00, 1'b1, REJECTED},
    '{1'b1, 16'hFFFF, 16'hFFFF, 4'd3, 64'h0A0A00, 1'b1, REJECTED},
    '{1'b1, 16'd0, 16'hFFFF, 4'd2, 64'h410A, 1'b1, REJECTED}
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [ucl_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [ucl_pkg::CFG_DATA_W-1:0] cfg_data_i;

  ucl_in_if  in_if ();
  ucl_out_if out_if ();

  utf8_cursor_locate dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Register copies and search state of the predictor.
  logic [15:0]     tgt_line      = '0;
  logic [15:0]     tgt_col       = '0;
  search_e         loc_phase     = SRCH_IDLE;
  logic [15:0]     lines_counted = '0;
  logic [15:0]     units_left    = '0;
  logic [1:0]      conts_left    = '0;
  lead_e           lead_kind     = LK_PLAIN;
  longint unsigned byte_pos      = 0;
  longint unsigned line_origin   = 0;

  ucl_pkg::out_beat_t pending_verdicts [$];
  logic [7:0]         text_buf [$];

  bit          in_idle_en  = 1'b1;
  bit          out_idle_en = 1'b1;
  bit          hold_req    = 1'b0;
  int unsigned fail_count    = 0;
  int unsigned texts_sent    = 0;
  int unsigned bytes_taken   = 0;
  int unsigned live_bytes    = 0;
  int unsigned settings_used = 0;
  int unsigned verdicts_seen = 0;
  int unsigned located       = 0;
  longint unsigned cycle_count = 0;

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic bit close_search(input bit ok, input longint unsigned cur,
                                      output ucl_pkg::out_beat_t v);
    v.found             = ok;
    v.cursor_offset     = ok ? cur[ucl_pkg::OUT_OFS_W-1:0] : '0;
    v.line_start_offset = line_origin[ucl_pkg::OUT_OFS_W-1:0];
    loc_phase = SRCH_IDLE;
    return 1'b1;
  endfunction

  function automatic bit enter_line(input longint unsigned start,
                                    output ucl_pkg::out_beat_t v);
    v = '0;
    if (start > OFS_MAX) return close_search(1'b0, 0, v);
    line_origin = start;
    units_left  = tgt_col;
    conts_left  = '0;
    lead_kind   = LK_PLAIN;
    loc_phase   = SRCH_LINE;
    if (units_left == 0) return close_search(1'b1, start, v);
    return 1'b0;
  endfunction

  // Advances the search by one accepted byte; returns 1 when a verdict falls on it.
  function automatic bit locate_byte(input logic [7:0] b, input logic fb,
                                     output ucl_pkg::out_beat_t v);
    longint unsigned nxt;
    logic [1:0]      more;
    bit              bad;
    v = '0;
    if (fb) begin
      lines_counted = '0;
      units_left    = '0;
      conts_left    = '0;
      lead_kind     = LK_PLAIN;
      byte_pos      = 0;
      line_origin   = 0;
      loc_phase     = SRCH_SKIP;
      if (tgt_line == 0) begin
        if (enter_line(0, v)) return 1'b1;
      end
    end else if (loc_phase == SRCH_IDLE) begin
      return 1'b0;
    end
    if (byte_pos > OFS_MAX) return close_search(1'b0, 0, v);
    nxt = byte_pos + 1;
    byte_pos = nxt;

    if (loc_phase == SRCH_SKIP) begin
      if (b == ucl_pkg::CHAR_NUL) return close_search(1'b0, 0, v);
      if (b == ucl_pkg::CHAR_LF) begin
        lines_counted = lines_counted + 16'd1;
        if (lines_counted == tgt_line) return enter_line(nxt, v);
      end
      return 1'b0;
    end

    if (conts_left == 0) begin
      if (b == ucl_pkg::CHAR_NUL || b == ucl_pkg::CHAR_CR || b == ucl_pkg::CHAR_LF)
        return close_search(1'b0, 0, v);
      if ((b >= ucl_pkg::ASCII_LIMIT && b < ucl_pkg::LEAD_MIN) || b > ucl_pkg::LEAD_MAX)
        return close_search(1'b0, 0, v);
      if (b < ucl_pkg::ASCII_LIMIT) begin
        units_left = units_left - 16'd1;
      end else begin
        more = (b < ucl_pkg::LEAD_3B_MIN) ? 2'd1 : (b < ucl_pkg::LEAD_4B_MIN) ? 2'd2 : 2'd3;
        // A four-byte character is a surrogate pair and takes two units.
        if (units_left < ((more == 2'd3) ? 16'd2 : 16'd1)) return close_search(1'b0, 0, v);
        units_left = units_left - ((more == 2'd3) ? 16'd2 : 16'd1);
        conts_left = more;
        lead_kind  = (b == ucl_pkg::LEAD_E0) ? LK_E0 : (b == ucl_pkg::LEAD_ED) ? LK_ED :
                     (b == ucl_pkg::LEAD_F0) ? LK_F0 : (b == ucl_pkg::LEAD_F4) ? LK_F4 :
                     LK_PLAIN;
        return 1'b0;
      end
    end else begin
      bad = (b & ucl_pkg::CONT_MASK) != ucl_pkg::CONT_TAG;
      if ((lead_kind == LK_E0 && b < ucl_pkg::E0_SECOND_MIN) ||
          (lead_kind == LK_ED && b >= ucl_pkg::ED_SECOND_LIM) ||
          (lead_kind == LK_F0 && b < ucl_pkg::F0_SECOND_MIN) ||
          (lead_kind == LK_F4 && b >= ucl_pkg::F4_SECOND_LIM))
        bad = 1'b1;
      if (bad) return close_search(1'b0, 0, v);
      lead_kind  = LK_PLAIN;
      conts_left = conts_left - 2'd1;
      if (conts_left != 0) return 1'b0;
    end

    if (units_left == 0) begin
      if (nxt > OFS_MAX) return close_search(1'b0, 0, v);
      return close_search(1'b1, nxt, v);
    end
    return 1'b0;
  endfunction

  task automatic check_verdict();
    ucl_pkg::out_beat_t exp;
    verdicts_seen++;
    if (out_if.found === 1'b1) located++;
    if (pending_verdicts.size() == 0) begin
      $error("unexpected verdict beat: found %0d cursor %0d line start %0d",
             out_if.found, out_if.cursor_offset, out_if.line_start_offset);
      fail_count++;
    end else begin
      exp = pending_verdicts.pop_front();
      if (out_if.found !== exp.found) begin
        $error("found: expected %0d, actual %0d", exp.found, out_if.found);
        fail_count++;
      end
      if (out_if.cursor_offset !== exp.cursor_offset) begin
        $error("cursor_offset: expected %0d, actual %0d", exp.cursor_offset,
               out_if.cursor_offset);
        fail_count++;
      end
      if (out_if.line_start_offset !== exp.line_start_offset) begin
        $error("line_start_offset: expected %0d, actual %0d", exp.line_start_offset,
               out_if.line_start_offset);
        fail_count++;
      end
    end
  endtask

  // Offers one byte until it is taken, then predicts its effect.
  task automatic push_byte(input logic [7:0] b, input logic fb, input bit typed,
                           input ucl_pkg::out_beat_t typed_exp);
    ucl_pkg::out_beat_t v;
    bit                 ignored;
    if (in_idle_en && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.text_byte  <= b;
    in_if.first_byte <= fb;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    ignored = !fb && loc_phase == SRCH_IDLE;
    if (locate_byte(b, fb, v)) pending_verdicts.push_back(typed ? typed_exp : v);
    bytes_taken++;
    if (!ignored) live_bytes++;
  endtask

  task automatic wait_for_verdicts();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
  endtask

  // Registers are read live, so a byte still in flight must have left the pipe first.
  task automatic program_target(input logic [15:0] line_v, input logic [15:0] col_v);
    wait_for_verdicts();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ucl_pkg::CFG_TARGET_LINE;
    cfg_data_i <= line_v;
    @(posedge clk_i);
    cfg_idx_i  <= ucl_pkg::CFG_TARGET_COLUMN;
    cfg_data_i <= col_v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tgt_line = line_v;
    tgt_col  = col_v;
    settings_used++;
  endtask

  // Mostly well-formed text: skipped lines, a target line of valid characters sized
  // around the column, a terminator, then a zero byte, with light noise on top.
  task automatic build_text();
    int unsigned n_skip, k, goal, units;
    logic [7:0]  lb, lead;
    text_buf.delete();
    n_skip = (tgt_line <= 4) ? 32'(tgt_line) : $urandom_range(0, 3);
    for (int l = 0; l < n_skip; l++) begin
      k = $urandom_range(0, 5);
      for (int j = 0; j < k; j++) begin
        lb = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) :
                                           8'($urandom_range(8'h20, 8'h7E));
        if (lb == ucl_pkg::CHAR_LF) lb = 8'h2E;
        text_buf.push_back(lb);
      end
      text_buf.push_back(ucl_pkg::CHAR_LF);
    end
    goal  = (tgt_col > 12) ? 12 : 32'(tgt_col) + $urandom_range(0, 1);
    units = 0;
    while (units < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          text_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
          units += 1;
        end
        5, 6: begin
          text_buf.push_back(8'($urandom_range(ucl_pkg::LEAD_MIN, 8'hDF)));
          text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
          units += 1;
        end
        7, 8: begin
          lead = 8'($urandom_range(ucl_pkg::LEAD_3B_MIN, 8'hEF));
          text_buf.push_back(lead);
          if (lead == ucl_pkg::LEAD_E0)
            text_buf.push_back(8'($urandom_range(ucl_pkg::E0_SECOND_MIN, 8'hBF)));
          else if (lead == ucl_pkg::LEAD_ED)
            text_buf.push_back(8'($urandom_range(8'h80, ucl_pkg::ED_SECOND_LIM - 8'd1)));
          else
            text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
          text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
          units += 1;
        end
        default: begin
          lead = 8'($urandom_range(ucl_pkg::LEAD_4B_MIN, ucl_pkg::LEAD_MAX));
          text_buf.push_back(lead);
          if (lead == ucl_pkg::LEAD_F0)
            text_buf.push_back(8'($urandom_range(ucl_pkg::F0_SECOND_MIN, 8'hBF)));
          else if (lead == ucl_pkg::LEAD_F4)
            text_buf.push_back(8'($urandom_range(8'h80, ucl_pkg::F4_SECOND_LIM - 8'd1)));
          else
            text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
          text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
          text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
          units += 2;
        end
      endcase
    end
    case ($urandom_range(0, 3))
      0:       text_buf.push_back(ucl_pkg::CHAR_NUL);
      1:       text_buf.push_back(ucl_pkg::CHAR_LF);
      2:       text_buf.push_back(ucl_pkg::CHAR_CR);
      default: text_buf.push_back(8'($urandom_range(1, 255)));
    endcase
    text_buf.push_back(ucl_pkg::CHAR_NUL);
    foreach (text_buf[i])
      if ($urandom_range(0, 29) == 0) text_buf[i] = 8'($urandom_range(0, 255));
  endtask

  initial begin : verdict_sink
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) check_verdict();
      if (stall_left != 0) stall_left--;
      else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (out_idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      out_if.ready <= (stall_left == 0);
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $error("timed out after %0d cycles with %0d verdicts pending", cycle_count,
           pending_verdicts.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_start, cut, r;
    logic [15:0] line_v, col_v;
    in_if.valid      = 1'b0;
    in_if.text_byte  = '0;
    in_if.first_byte = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    rst_ni           = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[row]) begin
      if (dir_rows[row].line != tgt_line || dir_rows[row].col != tgt_col)
        program_target(dir_rows[row].line, dir_rows[row].col);
      for (int i = 0; i < dir_rows[row].len; i++)
        push_byte(dir_rows[row].text[8 * (dir_rows[row].len - 1 - i) +: 8],
                  dir_rows[row].fresh && i == 0, dir_rows[row].typed, dir_rows[row].exp);
      if (dir_rows[row].fresh) texts_sent++;
    end

    // Every one-byte text gives an immediate hit, so a long receiver hold-off
    // fills the output stages and backs up the byte stream.
    program_target(16'd0, 16'd0);
    hold_req = 1'b1;
    repeat (PRESSURE_TEXTS) begin
      push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      texts_sent++;
    end
    wait_for_verdicts();

    for (int p = 1; p <= RAND_PHASES; p++) begin
      if (p == RAND_PHASES) begin
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
      end
      r = $urandom_range(0, 9);
      line_v = (r == 0) ? 16'hFFFF : 16'($urandom_range(0, 3));
      r = $urandom_range(0, 9);
      col_v = (r == 0) ? 16'hFFFF : (r == 1) ? 16'd0 : 16'($urandom_range(1, 8));
      program_target(line_v, col_v);
      phase_start = bytes_taken;
      while (bytes_taken - phase_start < PHASE_BYTES) begin
        build_text();
        // Now and then the next first byte cuts the text short.
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, text_buf.size()) : text_buf.size();
        for (int i = 0; i < cut; i++) push_byte(text_buf[i], i == 0, 1'b0, '0);
        texts_sent++;
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        if ($urandom_range(0, 24) == 0) wait_for_verdicts();
      end
    end

    wait_for_verdicts();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d texts in %0d bytes (%0d ignored) under %0d register settings.",
             texts_sent, bytes_taken, bytes_taken - live_bytes, settings_used);
    $display("Checked %0d verdicts: %0d located, %0d rejected; %0d mismatches.",
             verdicts_seen, located, verdicts_seen - located, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
